>>> src/plcl_pkg.sv
// ----------------------------------------------------------------------------
// plcl_pkg: shared types and constants of the piecewise linear curve lookup
// Request and status codes, item structs and arithmetic constants.
// ----------------------------------------------------------------------------
package plcl_pkg;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_EVAL  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    // divider operand width and its step counter width
    localparam int DIV_W  = 48;
    localparam int DIV_CW = 6;

    // normalized values span [0, 1.0] in Q0.16 and need 18 signed bits
    localparam int NV_W     = 18;
    localparam int YN_LIMIT = 1073741824;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         point_index;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] y_result;
        logic [1:0]         status;
    } t_res;

endpackage

>>> src/piecewise_linear_curve_lookup_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup_top: piecewise linear curve lookup
// Usage:
//   Slave stream carries request items: tuser is the request kind (load,
//   build, evaluate), tdata holds point index, x and y. Master stream returns
//   one item per request: tdata is y in Q16.16, tuser is the status.
//   The configuration channel writes the point count; it marks the grid unbuilt.
// Operation, one request at a time:
//   load writes one point. evaluate uses up to three passes of the
//   48-step shared divider (normalise x, cell index, segment interpolation)
//   plus memory reads and the partial products.
//   build: up to two normalizing divisions per point, then a grid walk over
//   GRID_CELLS cells with one extra point read per segment change.
//   GRID_CELLS must be a power of two.
// An input slot takes the next item while the engine works, and the output
// register holds a result while the receiver stalls; the engine then waits
// in its done state. Reset sets point count 2 and marks the grid unbuilt.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_lookup_top #(
    parameter int MAX_POINTS = 16,
    parameter int GRID_CELLS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] point_index, [35:4] x_value, [67:36] y_value, [71:68] zero
    input  logic [71:0] i_s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] y_result
    output logic [31:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    localparam int NW = $clog2(MAX_POINTS + 1);

    logic              r_in_valid;
    plcl_pkg::t_req    r_in;
    logic              r_out_valid;
    plcl_pkg::t_res    r_out;
    logic [4:0]        r_count;
    logic [NW-1:0]     used_count;
    logic              cfg_wr;
    logic              eng_ready, eng_valid, eng_take;
    plcl_pkg::t_res    eng_res;

    assign cfg_wr      = i_cfg_valid;
    assign o_cfg_ready = 1'b1;

    // clamp the count to the supported range
    always_comb begin
        if (r_count < 5'd2)                used_count = NW'(2);
        else if (32'(r_count) > MAX_POINTS) used_count = NW'(MAX_POINTS);
        else                               used_count = NW'(r_count);
    end

    assign o_s_axis_tready = !r_in_valid;
    assign eng_take        = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 5'd2;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) r_count <= i_cfg_data;
            // hold the item in the slot until the engine takes it
            if (i_s_axis_tvalid && !r_in_valid)  r_in_valid <= 1'b1;
            else if (r_in_valid && eng_ready)    r_in_valid <= 1'b0;
            if (eng_valid && eng_take)           r_out_valid <= 1'b1;
            else if (i_m_axis_tready)            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && !r_in_valid) begin
            r_in.req_type    <= i_s_axis_tuser;
            r_in.point_index <= i_s_axis_tdata[3:0];
            r_in.x_value     <= $signed(i_s_axis_tdata[35:4]);
            r_in.y_value     <= $signed(i_s_axis_tdata[67:36]);
        end
        if (eng_valid && eng_take) r_out <= eng_res;
    end

    plcl_engine #(
        .MAX_POINTS (MAX_POINTS),
        .GRID_CELLS (GRID_CELLS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_in_valid),
        .o_req_ready (eng_ready),
        .i_req       (r_in),
        .i_count     (used_count),
        .i_cfg_clr   (cfg_wr),
        .o_res_valid (eng_valid),
        .i_res_ready (eng_take),
        .o_res       (eng_res)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.y_result;
    assign o_m_axis_tuser  = r_out.status;

endmodule

>>> src/plcl_div.sv
// ----------------------------------------------------------------------------
// plcl_div: unsigned restoring divider
// One quotient bit per cycle; done pulses when quotient and remainder hold.
// ----------------------------------------------------------------------------
module plcl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plcl_pkg::DIV_W-1:0]  i_num,
    input  logic [plcl_pkg::DIV_W-1:0]  i_den,
    output logic                        o_done,
    output logic [plcl_pkg::DIV_W-1:0]  o_quo,
    output logic [plcl_pkg::DIV_W-1:0]  o_rem
);

    localparam int W = plcl_pkg::DIV_W;

    logic                          r_busy;
    logic                          r_done;
    logic [plcl_pkg::DIV_CW-1:0]   r_cnt;
    logic [W-1:0]                  r_quo;
    logic [W-1:0]                  r_rem;
    logic [W-1:0]                  r_den;
    logic [W:0]                    rem_sh;
    logic [W+1:0]                  trial;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= plcl_pkg::DIV_CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == plcl_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            // keep the trial difference when it does not go negative
            if (!trial[W+1]) begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> src/plcl_engine.sv
// ----------------------------------------------------------------------------
// plcl_engine: curve and grid memories with the request sequencer
// Loads points, builds the normalized curve and segment grid, evaluates.
// ----------------------------------------------------------------------------
module plcl_engine #(
    parameter int MAX_POINTS = 16,
    parameter int GRID_CELLS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  plcl_pkg::t_req                       i_req,
    input  logic [$clog2(MAX_POINTS+1)-1:0]      i_count,
    input  logic                                 i_cfg_clr,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output plcl_pkg::t_res                       o_res
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int GW  = $clog2(GRID_CELLS);
    localparam int RW  = GW + 1;
    localparam int QW  = 20;
    localparam int NV  = plcl_pkg::NV_W;
    localparam int DW  = plcl_pkg::DIV_W;
    localparam int PW  = 41;
    localparam int MW  = 50;
    localparam int OW  = 52;

    typedef enum logic [26:0] {
        S_IDLE      = 27'h0000001,
        S_SCAN_RD   = 27'h0000002,
        S_SCAN      = 27'h0000004,
        S_NORM_RD   = 27'h0000008,
        S_NX        = 27'h0000010,
        S_NX_WAIT   = 27'h0000020,
        S_NY        = 27'h0000040,
        S_NY_WAIT   = 27'h0000080,
        S_NORM_WR   = 27'h0000100,
        S_SPAN      = 27'h0000200,
        S_GNXT      = 27'h0000800,
        S_GCELL     = 27'h0001000,
        S_E_NORM    = 27'h0002000,
        S_E_CHK     = 27'h0004000,
        S_E_IDX     = 27'h0008000,
        S_E_SEG     = 27'h0010000,
        S_E_P0      = 27'h0020000,
        S_E_P1      = 27'h0040000,
        S_E_M1      = 27'h0080000,
        S_E_M2      = 27'h0100000,
        S_E_DIV     = 27'h0200000,
        S_E_DWAIT   = 27'h0400000,
        S_E_Y1      = 27'h0800000,
        S_E_Y2      = 27'h1000000,
        S_E_Y3      = 27'h2000000,
        S_DONE      = 27'h4000000
    } t_state;

    // memories
    logic [63:0]   m_curve [MAX_POINTS];
    logic [AW-1:0] m_grid  [GRID_CELLS];
    logic [63:0]   r_curve_rd;
    logic [AW-1:0] r_grid_rd;

    logic          c_we, c_re, g_we, g_re;
    logic [AW-1:0] c_wa, c_ra, g_wd;
    logic [63:0]   c_wd;
    logic [GW-1:0] g_wa, g_ra;

    // divider
    logic          d_start, d_done;
    logic [DW-1:0] d_num, d_den, d_quo, d_rem;

    // registers
    t_state                r_state, n_state;
    logic                  r_ready, n_ready;
    plcl_pkg::t_res        r_res, n_res;
    logic signed [31:0]    r_xlo, n_xlo, r_xhi, n_xhi, r_ylo, n_ylo, r_yhi, n_yhi;
    logic [AW-1:0]         r_i, n_i;
    logic signed [31:0]    r_pt_x, n_pt_x, r_pt_y, n_pt_y;
    logic signed [NV-1:0]  r_xn0, n_xn0, r_xnl, n_xnl, r_xt, n_xt, r_nxt_x, n_nxt_x;
    logic signed [NV-1:0]  r_xl, n_xl, r_xu, n_xu, r_yl, n_yl, r_yu, n_yu;
    logic [AW-1:0]         r_seg, n_seg;
    logic [GW-1:0]         r_t, n_t;
    logic signed [QW-1:0]  r_q, n_q, r_qs, n_qs;
    logic [RW-1:0]         r_r, n_r, r_rs, n_rs;
    logic signed [PW-1:0]  r_p1, n_p1, r_p2, n_p2;
    logic                  r_neg, n_neg;
    logic signed [31:0]    r_yn, n_yn;
    logic signed [MW-1:0]  r_plo, n_plo, r_phi, n_phi;

    // combinational helpers
    logic signed [32:0]    x_rng, y_rng;
    logic signed [NV:0]    span;
    logic [NV:0]           span_abs;
    logic [RW-1:0]         g_nr, g_nr2;
    logic                  g_carry, g_adv;
    logic signed [QW-1:0]  g_nq, g_xc;
    logic [AW-1:0]         g_segn;
    logic signed [NV:0]    e_d, e_dabs;
    logic signed [PW-1:0]  e_num;
    logic signed [MW-1:0]  e_q;
    logic signed [OW-1:0]  e_out;
    logic [31:0]           y_diff;
    logic [AW-1:0]         n_m1, n_m2;

    function automatic logic [DW-1:0] norm_num(input logic signed [31:0] v,
                                               input logic signed [31:0] lo);
        logic signed [32:0] df;
        df = 33'(v) - 33'(lo);
        return {df[31:0], 16'h0000};
    endfunction

    plcl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_done  (d_done),
        .o_quo   (d_quo),
        .o_rem   (d_rem)
    );

    always_ff @(posedge i_clk) begin
        if (c_we) m_curve[c_wa] <= c_wd;
        if (c_re) r_curve_rd <= m_curve[c_ra];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) m_grid[g_wa] <= g_wd;
        if (g_re) r_grid_rd <= m_grid[g_ra];
    end

    assign x_rng    = 33'(r_xhi) - 33'(r_xlo);
    assign y_rng    = 33'(r_yhi) - 33'(r_ylo);
    assign y_diff   = y_rng[31:0];
    assign span     = (NV+1)'(r_xnl) - (NV+1)'(r_xn0);
    assign span_abs = span[NV] ? $unsigned(-span) : $unsigned(span);
    assign n_m1     = AW'(i_count - 1'b1);
    assign n_m2     = AW'(i_count - 2'd2);

    // grid walk: advance cell start by span/GRID_CELLS with exact remainder
    assign g_nr    = r_r + r_rs;
    assign g_carry = g_nr >= RW'(GRID_CELLS);
    assign g_nr2   = g_carry ? g_nr - RW'(GRID_CELLS) : g_nr;
    assign g_nq    = r_q + r_qs + QW'(g_carry);
    assign g_xc    = QW'(r_xn0) + g_nq;
    assign g_adv   = ((32'(r_seg) + 1) < (32'(i_count) - 1)) && (g_xc >= QW'(r_nxt_x));
    assign g_segn  = r_seg + AW'(g_adv);

    assign e_d     = (NV+1)'(r_xu) - (NV+1)'(r_xl);
    assign e_dabs  = e_d[NV] ? -e_d : e_d;
    assign e_q     = r_neg ? -(MW'(d_quo)) - MW'(d_rem != '0) : MW'(d_quo);
    assign e_out   = OW'(r_ylo) + OW'(r_phi) + OW'(r_plo >>> 16);

    always_comb begin
        logic signed [PW-1:0] num_s;
        n_state = r_state;
        n_ready = r_ready;
        n_res   = r_res;
        n_xlo = r_xlo; n_xhi = r_xhi; n_ylo = r_ylo; n_yhi = r_yhi;
        n_i = r_i; n_pt_x = r_pt_x; n_pt_y = r_pt_y;
        n_xn0 = r_xn0; n_xnl = r_xnl; n_xt = r_xt; n_nxt_x = r_nxt_x;
        n_xl = r_xl; n_xu = r_xu; n_yl = r_yl; n_yu = r_yu;
        n_seg = r_seg; n_t = r_t; n_q = r_q; n_qs = r_qs; n_r = r_r; n_rs = r_rs;
        n_p1 = r_p1; n_p2 = r_p2; n_neg = r_neg; n_yn = r_yn;
        n_plo = r_plo; n_phi = r_phi;
        c_we = 1'b0; c_wa = '0; c_wd = '0; c_re = 1'b0; c_ra = '0;
        g_we = 1'b0; g_wa = '0; g_wd = '0; g_re = 1'b0; g_ra = '0;
        d_start = 1'b0; d_num = '0; d_den = '0;
        num_s = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res = '{y_result: '0, status: plcl_pkg::ST_OK};
                    n_state = S_DONE;
                    unique case (i_req.req_type)
                        plcl_pkg::REQ_LOAD: begin
                            if (32'(i_req.point_index) < MAX_POINTS) begin
                                c_we    = 1'b1;
                                c_wa    = AW'(i_req.point_index);
                                c_wd    = {i_req.y_value, i_req.x_value};
                                n_ready = 1'b0;
                            end
                        end
                        plcl_pkg::REQ_BUILD: begin
                            n_i     = '0;
                            n_state = S_SCAN_RD;
                        end
                        plcl_pkg::REQ_EVAL: begin
                            if (!r_ready) begin
                                n_res.status = plcl_pkg::ST_NOT_BUILT;
                            end else if (i_req.x_value < r_xlo || i_req.x_value > r_xhi) begin
                                n_res.status = plcl_pkg::ST_RANGE;
                            end else if (r_xhi == r_xlo) begin
                                n_xt    = '0;
                                n_state = S_E_CHK;
                            end else begin
                                d_start = 1'b1;
                                d_num   = norm_num(i_req.x_value, r_xlo);
                                d_den   = DW'(x_rng[31:0]);
                                n_state = S_E_NORM;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // min and max over the points in use
            S_SCAN_RD: begin
                c_re = 1'b1;
                c_ra = r_i;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_i == '0) begin
                    n_xlo = $signed(r_curve_rd[31:0]);
                    n_xhi = $signed(r_curve_rd[31:0]);
                    n_ylo = $signed(r_curve_rd[63:32]);
                    n_yhi = $signed(r_curve_rd[63:32]);
                end else begin
                    if ($signed(r_curve_rd[31:0]) > r_xhi) n_xhi = $signed(r_curve_rd[31:0]);
                    if ($signed(r_curve_rd[31:0]) < r_xlo) n_xlo = $signed(r_curve_rd[31:0]);
                    if ($signed(r_curve_rd[63:32]) > r_yhi) n_yhi = $signed(r_curve_rd[63:32]);
                    if ($signed(r_curve_rd[63:32]) < r_ylo) n_ylo = $signed(r_curve_rd[63:32]);
                end
                if (r_i == n_m1) begin
                    n_i     = '0;
                    n_state = S_NORM_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end

            // rewrite each point normalized
            S_NORM_RD: begin
                c_re = 1'b1;
                c_ra = r_i;
                n_state = S_NX;
            end
            S_NX: begin
                n_pt_y = $signed(r_curve_rd[63:32]);
                if (r_xhi == r_xlo) begin
                    n_pt_x  = '0;
                    n_state = S_NY;
                end else begin
                    d_start = 1'b1;
                    d_num   = norm_num($signed(r_curve_rd[31:0]), r_xlo);
                    d_den   = DW'(x_rng[31:0]);
                    n_state = S_NX_WAIT;
                end
            end
            S_NX_WAIT: begin
                if (d_done) begin
                    n_pt_x  = $signed(d_quo[31:0]);
                    n_state = S_NY;
                end
            end
            S_NY: begin
                if (r_yhi == r_ylo) begin
                    n_pt_y  = '0;
                    n_state = S_NORM_WR;
                end else begin
                    d_start = 1'b1;
                    d_num   = norm_num(r_pt_y, r_ylo);
                    d_den   = DW'(y_rng[31:0]);
                    n_state = S_NY_WAIT;
                end
            end
            S_NY_WAIT: begin
                if (d_done) begin
                    n_pt_y  = $signed(d_quo[31:0]);
                    n_state = S_NORM_WR;
                end
            end
            S_NORM_WR: begin
                c_we = 1'b1;
                c_wa = r_i;
                c_wd = {r_pt_y, r_pt_x};
                if (r_i == '0) n_xn0 = NV'(r_pt_x);
                if (r_i == n_m1) begin
                    n_xnl   = NV'(r_pt_x);
                    n_state = S_SPAN;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_NORM_RD;
                end
            end

            // span per cell as whole part and remainder; the cell count is a
            // power of two, so a shift and a mask split it
            S_SPAN: begin
                if (span[NV] && span_abs[GW-1:0] != '0) begin
                    n_qs = -QW'(span_abs >> GW) - QW'(1);
                    n_rs = RW'(GRID_CELLS) - RW'(span_abs[GW-1:0]);
                end else if (span[NV]) begin
                    n_qs = -QW'(span_abs >> GW);
                    n_rs = '0;
                end else begin
                    n_qs = QW'(span_abs >> GW);
                    n_rs = RW'(span_abs[GW-1:0]);
                end
                g_we    = 1'b1;
                g_wa    = '0;
                g_wd    = '0;
                c_re    = 1'b1;
                c_ra    = AW'(1);
                n_seg   = '0;
                n_t     = GW'(1);
                n_q     = '0;
                n_r     = '0;
                n_state = S_GNXT;
            end
            S_GNXT: begin
                n_nxt_x = NV'($signed(r_curve_rd[31:0]));
                n_state = S_GCELL;
            end
            S_GCELL: begin
                g_we  = 1'b1;
                g_wa  = r_t;
                g_wd  = g_segn;
                n_q   = g_nq;
                n_r   = g_nr2;
                n_seg = g_segn;
                n_t   = r_t + 1'b1;
                if (r_t == GW'(GRID_CELLS - 1)) begin
                    n_ready = 1'b1;
                    n_state = S_DONE;
                end else if (g_adv && ((32'(g_segn) + 1) < (32'(i_count) - 1))) begin
                    c_re    = 1'b1;
                    c_ra    = g_segn + 1'b1;
                    n_state = S_GNXT;
                end
            end

            // evaluate
            S_E_NORM: begin
                if (d_done) begin
                    n_xt    = $signed(d_quo[NV-1:0]);
                    n_state = S_E_CHK;
                end
            end
            S_E_CHK: begin
                if (r_xt < r_xn0 || r_xt > r_xnl) begin
                    n_res.status = plcl_pkg::ST_RANGE;
                    n_state      = S_DONE;
                end else if (span > 0) begin
                    d_start = 1'b1;
                    d_num   = DW'($unsigned(r_xt - r_xn0)) * DW'(2 * GRID_CELLS)
                              + DW'(span_abs);
                    d_den   = DW'(span_abs) << 1;
                    n_state = S_E_IDX;
                end else begin
                    g_re    = 1'b1;
                    g_ra    = '0;
                    n_state = S_E_SEG;
                end
            end
            S_E_IDX: begin
                if (d_done) begin
                    g_re    = 1'b1;
                    g_ra    = (d_quo > DW'(GRID_CELLS - 1)) ? GW'(GRID_CELLS - 1)
                                                          : d_quo[GW-1:0];
                    n_state = S_E_SEG;
                end
            end
            S_E_SEG: begin
                n_seg   = (r_grid_rd > n_m2) ? n_m2 : r_grid_rd;
                c_re    = 1'b1;
                c_ra    = (r_grid_rd > n_m2) ? n_m2 : r_grid_rd;
                n_state = S_E_P0;
            end
            S_E_P0: begin
                n_xl    = NV'($signed(r_curve_rd[31:0]));
                n_yl    = NV'($signed(r_curve_rd[63:32]));
                c_re    = 1'b1;
                c_ra    = r_seg + 1'b1;
                n_state = S_E_P1;
            end
            S_E_P1: begin
                n_xu    = NV'($signed(r_curve_rd[31:0]));
                n_yu    = NV'($signed(r_curve_rd[63:32]));
                n_state = S_E_M1;
            end
            S_E_M1: begin
                n_p1    = PW'(r_yl) * PW'(e_d);
                n_state = S_E_M2;
            end
            S_E_M2: begin
                n_p2    = (PW'(r_yu) - PW'(r_yl)) * (PW'(r_xt) - PW'(r_xl));
                n_state = S_E_DIV;
            end
            S_E_DIV: begin
                if (e_d == '0) begin
                    n_yn    = 32'(r_yl);
                    n_state = S_E_Y1;
                end else begin
                    num_s   = e_d[NV] ? -(r_p1 + r_p2) : (r_p1 + r_p2);
                    n_neg   = num_s[PW-1];
                    d_start = 1'b1;
                    d_num   = DW'($unsigned(num_s[PW-1] ? -num_s : num_s));
                    d_den   = DW'($unsigned(e_dabs));
                    n_state = S_E_DWAIT;
                end
            end
            S_E_DWAIT: begin
                if (d_done) begin
                    if (e_q > MW'(plcl_pkg::YN_LIMIT))       n_yn = 32'(plcl_pkg::YN_LIMIT);
                    else if (e_q < -MW'(plcl_pkg::YN_LIMIT)) n_yn = -32'(plcl_pkg::YN_LIMIT);
                    else                                     n_yn = 32'(e_q);
                    n_state = S_E_Y1;
                end
            end
            // scale by the y range in two half-width products
            S_E_Y1: begin
                n_plo   = MW'(r_yn) * MW'({1'b0, y_diff[15:0]});
                n_state = S_E_Y2;
            end
            S_E_Y2: begin
                n_phi   = MW'(r_yn) * MW'({1'b0, y_diff[31:16]});
                n_state = S_E_Y3;
            end
            S_E_Y3: begin
                if (e_out > OW'(32'sh7FFFFFFF))       n_res.y_result = 32'sh7FFFFFFF;
                else if (e_out < -OW'(33'sh80000000)) n_res.y_result = 32'sh80000000;
                else                                  n_res.y_result = 32'(e_out);
                n_res.status = plcl_pkg::ST_OK;
                n_state      = S_DONE;
            end

            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_clr) n_ready = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_xlo   <= '0;
            r_xhi   <= '0;
            r_ylo   <= '0;
            r_yhi   <= '0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_xlo   <= n_xlo;
            r_xhi   <= n_xhi;
            r_ylo   <= n_ylo;
            r_yhi   <= n_yhi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res; r_i <= n_i; r_pt_x <= n_pt_x; r_pt_y <= n_pt_y;
        r_xn0 <= n_xn0; r_xnl <= n_xnl; r_xt <= n_xt; r_nxt_x <= n_nxt_x;
        r_xl <= n_xl; r_xu <= n_xu; r_yl <= n_yl; r_yu <= n_yu;
        r_seg <= n_seg; r_t <= n_t; r_q <= n_q; r_qs <= n_qs; r_r <= n_r; r_rs <= n_rs;
        r_p1 <= n_p1; r_p2 <= n_p2; r_neg <= n_neg; r_yn <= n_yn;
        r_plo <= n_plo; r_phi <= n_phi;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule
